### rtl/core/axr_pkg.sv
package axr_pkg;

	localparam int DATA_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// Axis magnitudes are brought to 15 bits before the square root.
	localparam int MAG_W      = 15;
	localparam int SUM_W      = 32;
	localparam int ROOT_W     = 32;
	localparam int REM_W      = 34;
	localparam int SQRT_STEPS = 32;
	localparam int Q_W        = 18;
	localparam int DREM_W     = 50;

	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

	typedef struct packed {
		logic                         deg;
		logic [2:0]                   neg;
		logic [2:0][MAG_W-1:0]        mag;
		logic [SUM_W-1:0]             nsh;
		logic [REM_W-1:0]             rem;
		logic [ROOT_W-1:0]            root;
		logic signed [32:0]           cx;
		logic signed [32:0]           cy;
		logic signed [32:0]           cz;
		logic                         flip;
	} sq_t;

	typedef struct packed {
		logic                         deg;
		logic [2:0]                   neg;
		logic [ROOT_W-1:0]            root;
		logic [2:0][DREM_W-1:0]       rem;
		logic [2:0][Q_W-1:0]          q;
		logic signed [32:0]           cx;
		logic signed [32:0]           cy;
		logic                         flip;
	} div_t;

	// Arctangent of 2^-k, 2^32 counts per turn.
	function automatic logic [31:0] atan_val(input int k);
		logic [31:0] r;
		case (k)
			0: r = 32'h20000000;
			1: r = 32'h12e4051e;
			2: r = 32'h09fb385b;
			3: r = 32'h051111d4;
			4: r = 32'h028b0d43;
			5: r = 32'h0145d7e1;
			6: r = 32'h00a2f61e;
			7: r = 32'h00517c55;
			8: r = 32'h0028be53;
			9: r = 32'h00145f2f;
			10: r = 32'h000a2f98;
			11: r = 32'h000517cc;
			12: r = 32'h00028be6;
			13: r = 32'h000145f3;
			14: r = 32'h0000a2fa;
			15: r = 32'h0000517d;
			16: r = 32'h000028be;
			17: r = 32'h0000145f;
			18: r = 32'h00000a30;
			19: r = 32'h00000518;
			20: r = 32'h0000028c;
			21: r = 32'h00000146;
			22: r = 32'h000000a3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000a;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/axr_in_if.sv
interface axr_in_if #(
	parameter int W = axr_pkg::DATA_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] axis_x;
	logic signed [W-1:0] axis_y;
	logic signed [W-1:0] axis_z;
	logic signed [W-1:0] rot_angle;

	modport source(output valid, output axis_x, output axis_y, output axis_z,
		output rot_angle, input ready);
	modport sink(input valid, input axis_x, input axis_y, input axis_z,
		input rot_angle, output ready);
endinterface

### rtl/core/axr_out_if.sv
interface axr_out_if #(
	parameter int W = axr_pkg::DATA_WIDTH_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] r00;
	logic signed [W-1:0] r01;
	logic signed [W-1:0] r02;
	logic signed [W-1:0] r10;
	logic signed [W-1:0] r11;
	logic signed [W-1:0] r12;
	logic signed [W-1:0] r20;
	logic signed [W-1:0] r21;
	logic signed [W-1:0] r22;
	logic                degenerate_axis;

	modport source(output valid, output r00, output r01, output r02, output r10,
		output r11, output r12, output r20, output r21, output r22,
		output degenerate_axis, input ready);
	modport sink(input valid, input r00, input r01, input r02, input r10,
		input r11, input r12, input r20, input r21, input r22,
		input degenerate_axis, output ready);
endinterface

### rtl/core/axis_angle_to_rotation_matrix_top.sv
// Axis-angle to rotation matrix by the Rodrigues formula. Each input item holds
// a signed axis (any common scale, normalized inside) and a binary angle with
// one turn over the full field range; each result item holds the nine row-major
// elements of R = c*I + s*[u]x + (1-c)*u*u^T in signed Q2.(DATA_WIDTH-2), rounded
// and saturated, and a flag that marks an all-zero axis, for which the identity
// is returned. The pipeline takes one item in every cycle while it is not held
// and gives one result per item, in order, through axis scaling and sum of
// squares, a bit-per-stage square root whose first CORDIC_STAGES stages also
// carry the CORDIC sine/cosine rotations, a bit-per-stage divide that forms
// the unit axis, and multiplies, sums and rounding ending in the output
// register. The whole pipeline advances together: it holds only while the
// output register is full and the sink is not ready, so ready can fall only
// in that case.
module axis_angle_to_rotation_matrix_top #(
	parameter int DATA_WIDTH    = axr_pkg::DATA_WIDTH_DEF,
	parameter int CORDIC_STAGES = axr_pkg::CORDIC_STAGES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	axr_in_if.sink       axis_item,
	axr_out_if.source    matrix_item
);
	localparam int NSQ  = axr_pkg::SQRT_STEPS;
	localparam int NDIV = axr_pkg::Q_W;
	localparam int FRAC = DATA_WIDTH - 2;

	logic en;

	logic          sq_v [0:NSQ];
	axr_pkg::sq_t  sq_d [0:NSQ];
	logic          dv_v [0:NDIV];
	axr_pkg::div_t dv_d [0:NDIV];

	logic [8:0][DATA_WIDTH-1:0] elem;
	logic                       deg;
	logic                       out_v;

	// Every stage moves when the output register is empty or being taken.
	assign en              = !out_v || matrix_item.ready;
	assign axis_item.ready = en;

	axr_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_in  (axis_item.valid),
		.ax    (axis_item.axis_x),
		.ay    (axis_item.axis_y),
		.az    (axis_item.axis_z),
		.ang   (axis_item.rot_angle),
		.v_out (sq_v[0]),
		.d_out (sq_d[0])
	);

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		axr_sqrt_stage #(.IDX(g), .CORDIC_STAGES(CORDIC_STAGES)) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (sq_v[g]),
			.d_in  (sq_d[g]),
			.v_out (sq_v[g+1]),
			.d_out (sq_d[g+1])
		);
	end

	// The divide starts from the scaled magnitude times 2^32 and the root.
	always_comb begin
		dv_v[0]      = sq_v[NSQ];
		dv_d[0].deg  = sq_d[NSQ].deg;
		dv_d[0].neg  = sq_d[NSQ].neg;
		dv_d[0].root = sq_d[NSQ].root;
		for (int i = 0; i < 3; i++) begin
			dv_d[0].rem[i] = axr_pkg::DREM_W'({sq_d[NSQ].mag[i], 32'b0});
		end
		dv_d[0].q    = '0;
		dv_d[0].cx   = sq_d[NSQ].cx;
		dv_d[0].cy   = sq_d[NSQ].cy;
		dv_d[0].flip = sq_d[NSQ].flip;
	end

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		axr_div_stage #(.K(NDIV - 1 - g)) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (dv_v[g]),
			.d_in  (dv_d[g]),
			.v_out (dv_v[g+1]),
			.d_out (dv_d[g+1])
		);
	end

	axr_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (dv_v[NDIV]),
		.d_in   (dv_d[NDIV]),
		.v_out  (out_v),
		.elem   (elem),
		.deg_out(deg)
	);

	assign matrix_item.valid           = out_v;
	assign matrix_item.r00             = elem[0];
	assign matrix_item.r01             = elem[1];
	assign matrix_item.r02             = elem[2];
	assign matrix_item.r10             = elem[3];
	assign matrix_item.r11             = elem[4];
	assign matrix_item.r12             = elem[5];
	assign matrix_item.r20             = elem[6];
	assign matrix_item.r21             = elem[7];
	assign matrix_item.r22             = elem[8];
	assign matrix_item.degenerate_axis = deg;

	// A degenerate item carries the identity on the diagonal.
	a_deg_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v && deg) |-> (elem[0] == DATA_WIDTH'(1 << FRAC)
			&& elem[4] == DATA_WIDTH'(1 << FRAC) && elem[8] == DATA_WIDTH'(1 << FRAC)))
		else $error("degenerate item without unit diagonal");

	// A degenerate item carries zeros off the diagonal.
	a_deg_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v && deg) |-> (elem[1] == '0 && elem[2] == '0 && elem[3] == '0
			&& elem[5] == '0 && elem[6] == '0 && elem[7] == '0))
		else $error("degenerate item with nonzero off-diagonal element");

	// A stalled result stays in the output register.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v && !matrix_item.ready) |=> (out_v && $stable(elem) && $stable(deg)))
		else $error("stalled result lost or changed");
endmodule

### rtl/core/axr_front.sv
module axr_front #(
	parameter int DATA_WIDTH = axr_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         v_in,
	input  logic signed [DATA_WIDTH-1:0] ax,
	input  logic signed [DATA_WIDTH-1:0] ay,
	input  logic signed [DATA_WIDTH-1:0] az,
	input  logic signed [DATA_WIDTH-1:0] ang,
	output logic                         v_out,
	output axr_pkg::sq_t                 d_out
);
	localparam int PW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

	logic [2:0][DATA_WIDTH-1:0]        mag;
	logic [2:0]                        neg;
	logic [DATA_WIDTH-1:0]             mx;
	logic [PW-1:0]                     lead;
	logic [2:0][DATA_WIDTH+13:0]       wide;
	logic [31:0]                       phase;
	logic                              flip;

	logic                              v_s1;
	logic                              deg_s1;
	logic [2:0]                        neg_s1;
	logic [2:0][axr_pkg::MAG_W-1:0]    mag_s1;
	logic signed [32:0]                z_s1;
	logic                              flip_s1;

	always_comb begin
		logic signed [DATA_WIDTH-1:0] a [3];
		a[0] = ax;
		a[1] = ay;
		a[2] = az;
		mx = '0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = a[i][DATA_WIDTH-1];
			mag[i] = neg[i] ? DATA_WIDTH'(-a[i]) : DATA_WIDTH'(a[i]);
			if (mag[i] > mx) begin
				mx = mag[i];
			end
		end
		lead = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (mx[i]) begin
				lead = PW'(i);
			end
		end
		// One common shift puts the largest magnitude in [2^14, 2^15).
		for (int i = 0; i < 3; i++) begin
			wide[i] = {mag[i], 14'b0} >> lead;
		end
		phase = 32'(ang) << (32 - DATA_WIDTH);
		// Second and third quadrant move by half a turn.
		flip = phase[31] ^ phase[30];
		if (flip) begin
			phase[31] = ~phase[31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1  <= (mx == '0);
			neg_s1  <= neg;
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= wide[i][axr_pkg::MAG_W-1:0];
			end
			z_s1    <= 33'(signed'(phase));
			flip_s1 <= flip;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out.deg  <= deg_s1;
			d_out.neg  <= neg_s1;
			d_out.mag  <= mag_s1;
			d_out.nsh  <= {17'b0, mag_s1[0]} * {17'b0, mag_s1[0]}
				+ {17'b0, mag_s1[1]} * {17'b0, mag_s1[1]}
				+ {17'b0, mag_s1[2]} * {17'b0, mag_s1[2]};
			d_out.rem  <= '0;
			d_out.root <= '0;
			d_out.cx   <= axr_pkg::CORDIC_X0;
			d_out.cy   <= '0;
			d_out.cz   <= z_s1;
			d_out.flip <= flip_s1;
		end
	end
endmodule

### rtl/core/axr_sqrt_stage.sv
module axr_sqrt_stage #(
	parameter int IDX           = 0,
	parameter int CORDIC_STAGES = axr_pkg::CORDIC_STAGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_in,
	input  axr_pkg::sq_t d_in,
	output logic         v_out,
	output axr_pkg::sq_t d_out
);
	localparam bit DO_ROT = (IDX < CORDIC_STAGES);
	localparam logic signed [32:0] ATAN = 33'(axr_pkg::atan_val(IDX));

	axr_pkg::sq_t nxt;
	logic [35:0]  trial;
	logic [35:0]  tv;

	always_comb begin
		nxt   = d_in;
		// One root bit per step from two bits of the radicand.
		trial = {d_in.rem, d_in.nsh[31:30]};
		tv    = {2'b0, d_in.root, 2'b01};
		nxt.nsh = {d_in.nsh[29:0], 2'b00};
		if (trial >= tv) begin
			nxt.rem  = 34'(trial - tv);
			nxt.root = {d_in.root[30:0], 1'b1};
		end else begin
			nxt.rem  = trial[33:0];
			nxt.root = {d_in.root[30:0], 1'b0};
		end
		if (DO_ROT) begin
			if (d_in.cz >= 0) begin
				nxt.cx = d_in.cx - (d_in.cy >>> IDX);
				nxt.cy = d_in.cy + (d_in.cx >>> IDX);
				nxt.cz = d_in.cz - ATAN;
			end else begin
				nxt.cx = d_in.cx + (d_in.cy >>> IDX);
				nxt.cy = d_in.cy - (d_in.cx >>> IDX);
				nxt.cz = d_in.cz + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

### rtl/core/axr_div_stage.sv
module axr_div_stage #(
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  axr_pkg::div_t d_in,
	output logic          v_out,
	output axr_pkg::div_t d_out
);
	axr_pkg::div_t                nxt;
	logic [axr_pkg::DREM_W-1:0]   dv;

	always_comb begin
		nxt = d_in;
		dv  = axr_pkg::DREM_W'(d_in.root) << K;
		for (int i = 0; i < 3; i++) begin
			if (d_in.rem[i] >= dv) begin
				nxt.rem[i]  = d_in.rem[i] - dv;
				nxt.q[i][K] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

### rtl/core/axr_back.sv
module axr_back #(
	parameter int DATA_WIDTH = axr_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  axr_pkg::div_t               d_in,
	output logic                        v_out,
	output logic [8:0][DATA_WIDTH-1:0]  elem,
	output logic                        deg_out
);
	localparam int FRAC = DATA_WIDTH - 2;
	localparam logic signed [63:0] RND = 64'sd1 <<< (59 - FRAC);
	localparam logic signed [63:0] HI  = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] LO  = -HI - 64'sd1;
	localparam logic signed [31:0] ONE30 = 32'sd1073741824;
	localparam int Q_PLUS = axr_pkg::Q_W + 1;

	logic v_s1, v_s2, v_s3;
	logic deg_s1, deg_s2, deg_s3;

	logic signed [16:0]      u_s1 [3];
	logic signed [31:0]      cs_s1;
	logic signed [31:0]      sn_s1;

	logic signed [33:0]      uu_s2 [6];
	logic signed [48:0]      su_s2 [3];
	logic signed [32:0]      t_s2;
	logic signed [63:0]      c_s2;

	logic signed [63:0]      p_s3 [6];
	logic signed [63:0]      s_s3 [3];
	logic signed [63:0]      c_s3;

	logic signed [16:0]      u_n [3];
	logic signed [31:0]      cs_n;
	logic signed [31:0]      sn_n;
	logic signed [63:0]      e [9];
	logic [8:0][DATA_WIDTH-1:0] sat;

	always_comb begin
		logic [Q_PLUS-1:0] qr;
		logic signed [32:0] xc;
		logic signed [32:0] yc;
		for (int i = 0; i < 3; i++) begin
			qr = (Q_PLUS'(d_in.q[i]) + Q_PLUS'(1)) >> 1;
			if (qr > Q_PLUS'(32768)) begin
				qr = Q_PLUS'(32768);
			end
			u_n[i] = d_in.neg[i] ? -$signed({1'b0, qr[15:0]}) : $signed({1'b0, qr[15:0]});
		end
		xc = d_in.cx;
		yc = d_in.cy;
		if (xc > 33'sd1073741824) xc = 33'sd1073741824;
		if (xc < -33'sd1073741824) xc = -33'sd1073741824;
		if (yc > 33'sd1073741824) yc = 33'sd1073741824;
		if (yc < -33'sd1073741824) yc = -33'sd1073741824;
		cs_n = d_in.flip ? -32'(xc) : 32'(xc);
		sn_n = d_in.flip ? -32'(yc) : 32'(yc);
	end

	always_comb begin
		logic signed [63:0] r;
		e[0] = p_s3[0] + c_s3;
		e[1] = p_s3[3] - s_s3[2];
		e[2] = p_s3[4] + s_s3[1];
		e[3] = p_s3[3] + s_s3[2];
		e[4] = p_s3[1] + c_s3;
		e[5] = p_s3[5] - s_s3[0];
		e[6] = p_s3[4] - s_s3[1];
		e[7] = p_s3[5] + s_s3[0];
		e[8] = p_s3[2] + c_s3;
		for (int i = 0; i < 9; i++) begin
			r = (e[i] + RND) >>> (60 - FRAC);
			if (r > HI) begin
				r = HI;
			end else if (r < LO) begin
				r = LO;
			end
			if (deg_s3) begin
				// A zero axis gives the identity matrix.
				r = (i == 0 || i == 4 || i == 8) ? (64'sd1 <<< FRAC) : 64'sd0;
			end
			sat[i] = r[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_out <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s1 <= d_in.deg;
			u_s1   <= u_n;
			cs_s1  <= cs_n;
			sn_s1  <= sn_n;

			deg_s2   <= deg_s1;
			uu_s2[0] <= u_s1[0] * u_s1[0];
			uu_s2[1] <= u_s1[1] * u_s1[1];
			uu_s2[2] <= u_s1[2] * u_s1[2];
			uu_s2[3] <= u_s1[0] * u_s1[1];
			uu_s2[4] <= u_s1[0] * u_s1[2];
			uu_s2[5] <= u_s1[1] * u_s1[2];
			for (int i = 0; i < 3; i++) begin
				su_s2[i] <= sn_s1 * u_s1[i];
			end
			t_s2 <= 33'(ONE30) - 33'(cs_s1);
			c_s2 <= 64'(cs_s1) <<< 30;

			deg_s3 <= deg_s2;
			for (int i = 0; i < 6; i++) begin
				p_s3[i] <= t_s2 * uu_s2[i];
			end
			for (int i = 0; i < 3; i++) begin
				s_s3[i] <= 64'(su_s2[i]) <<< 15;
			end
			c_s3 <= c_s2;

			elem    <= sat;
			deg_out <= deg_s3;
		end
	end
endmodule

### tb/rotation_matrix_checker.sv
`timescale 1ns / 100ps

module rotation_matrix_checker (
	input  logic clk,
	input  logic arst_n,
	axr_in_if    axis_ch,
	axr_out_if   matrix_ch,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic [8:0][15:0] elem;
		logic             deg;
	} matrix_t;

	localparam logic [31:0] ATAN_LUT [16] = '{
		32'h20000000, 32'h12e4051e, 32'h09fb385b, 32'h051111d4,
		32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
		32'h0028be53, 32'h00145f2f, 32'h000a2f98, 32'h000517cc,
		32'h00028be6, 32'h000145f3, 32'h0000a2fa, 32'h0000517d
	};

	matrix_t matrix_q[$];

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] round_sat(input longint acc);
		longint r;
		r = (acc + (longint'(1) << 45)) >>> 46;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic matrix_t rodrigues(input logic signed [15:0] ax, ay, az, ang);
		matrix_t m;
		longint unsigned mag[3];
		longint unsigned mx, sum, root, q;
		logic neg[3];
		longint a, u[3], x, y, z, dx, dy, sn, cs, t, c60, sx, sy, sz, txy, txz, tyz;
		logic [31:0] phase;
		logic flip;
		longint e[9];
		a = ax; neg[0] = a < 0; mag[0] = neg[0] ? -a : a;
		a = ay; neg[1] = a < 0; mag[1] = neg[1] ? -a : a;
		a = az; neg[2] = a < 0; mag[2] = neg[2] ? -a : a;
		mx = mag[0];
		if (mag[1] > mx) mx = mag[1];
		if (mag[2] > mx) mx = mag[2];
		m.deg = 1'b0;
		if (mx == 0) begin
			for (int i = 0; i < 9; i++) m.elem[i] = (i % 4 == 0) ? 16'h4000 : 16'h0000;
			m.deg = 1'b1;
			return m;
		end
		while (mx >= (64'd1 << 15)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (mx < (64'd1 << 14)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		root = int_sqrt(sum << 32);
		for (int i = 0; i < 3; i++) begin
			q = (((mag[i] << 32) / root) + 1) >> 1;
			if (q > (64'd1 << 15)) q = 64'd1 << 15;
			u[i] = neg[i] ? -longint'(q) : longint'(q);
		end

		// Quadrant folding keeps the CORDIC within its convergence range.
		phase = {ang, 16'h0000};
		flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
		if (flip) phase += 32'h80000000;
		z = longint'(signed'(phase));
		x = 652032874;
		y = 0;
		for (int k = 0; k < 16; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_LUT[k];
			end else begin
				x += dx; y -= dy; z += ATAN_LUT[k];
			end
		end
		if (x > (longint'(1) << 30)) x = longint'(1) << 30;
		if (x < -(longint'(1) << 30)) x = -(longint'(1) << 30);
		if (y > (longint'(1) << 30)) y = longint'(1) << 30;
		if (y < -(longint'(1) << 30)) y = -(longint'(1) << 30);
		cs = flip ? -x : x;
		sn = flip ? -y : y;

		t = (longint'(1) << 30) - cs;
		c60 = cs * (longint'(1) << 30);
		sx = sn * u[0] * 32768;
		sy = sn * u[1] * 32768;
		sz = sn * u[2] * 32768;
		txy = t * (u[0] * u[1]);
		txz = t * (u[0] * u[2]);
		tyz = t * (u[1] * u[2]);
		e[0] = t * (u[0] * u[0]) + c60;
		e[1] = txy - sz;
		e[2] = txz + sy;
		e[3] = txy + sz;
		e[4] = t * (u[1] * u[1]) + c60;
		e[5] = tyz - sx;
		e[6] = txz - sy;
		e[7] = tyz + sx;
		e[8] = t * (u[2] * u[2]) + c60;
		for (int i = 0; i < 9; i++) m.elem[i] = round_sat(e[i]);
		return m;
	endfunction

	assign outstanding = matrix_q.size();

	always @(posedge clk or negedge arst_n) begin
		matrix_t want, got;
		if (!arst_n) begin
			mismatches <= 0;
		end else begin
			if (axis_ch.valid && axis_ch.ready)
				matrix_q.push_back(rodrigues(axis_ch.axis_x, axis_ch.axis_y,
					axis_ch.axis_z, axis_ch.rot_angle));
			if (matrix_ch.valid && matrix_ch.ready) begin
				got.elem = {matrix_ch.r22, matrix_ch.r21, matrix_ch.r20,
					matrix_ch.r12, matrix_ch.r11, matrix_ch.r10,
					matrix_ch.r02, matrix_ch.r01, matrix_ch.r00};
				got.deg = matrix_ch.degenerate_axis;
				if (matrix_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result item at %0t", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					want = matrix_q.pop_front();
					if (want != got) begin
						if (mismatches < 10) begin
							$display("mismatch at %0t", $realtime);
							for (int i = 0; i < 9; i++)
								if (want.elem[i] != got.elem[i])
									$display("  r%0d%0d expected %0d got %0d", i / 3, i % 3,
										$signed(want.elem[i]), $signed(got.elem[i]));
							if (want.deg != got.deg)
								$display("  degenerate_axis expected %0b got %0b",
									want.deg, got.deg);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   idle_cycles = 0;
	bit   stimulus_done;

	axr_in_if  axis_ch ();
	axr_out_if matrix_ch ();

	axis_angle_to_rotation_matrix_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.axis_item   (axis_ch),
		.matrix_item (matrix_ch)
	);

	// The checker sees both channels, predicts every matrix and reports
	// how many results went wrong and how many are still in flight.
	rotation_matrix_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.axis_ch     (axis_ch),
		.matrix_ch   (matrix_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Sends one item and holds it until the block takes it. Inputs are
	// sampled right after the edge, before any update of that edge lands.
	task automatic send_axis(input logic [15:0] x, y, z, ang);
		axis_ch.valid     <= 1'b1;
		axis_ch.axis_x    <= x;
		axis_ch.axis_y    <= y;
		axis_ch.axis_z    <= z;
		axis_ch.rot_angle <= ang;
		do @(posedge clk); while (!axis_ch.ready);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			axis_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// A random axis component: full range most of the time, otherwise a
	// small value, so the prescaling shifts both ways get exercised.
	function automatic logic [15:0] rand_comp(input bit tiny);
		logic [15:0] v;
		v = 16'($urandom());
		if (tiny) v = $signed(v) >>> $urandom_range(15, 6);
		return v;
	endfunction

	// Directed angles: zero, quarter turns both ways, half turn, largest, eighth turn, one step both ways.
	localparam logic [15:0] ANGLES [8] = '{16'h0000, 16'h4000, 16'hc000, 16'h8000,
		16'h7fff, 16'h2000, 16'h0001, 16'hffff};

	initial begin
		bit tiny;
		logic [15:0] x, y, z;
		arst_n              = 1'b0;
		stimulus_done       = 1'b0;
		axis_ch.valid       = 1'b0;
		axis_ch.axis_x      = '0;
		axis_ch.axis_y      = '0;
		axis_ch.axis_z      = '0;
		axis_ch.rot_angle   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Zero axis gives the identity and the degenerate flag.
		send_axis(16'h0000, 16'h0000, 16'h0000, 16'h4000);
		send_axis(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		// Extremes of the components, including the most negative value.
		send_axis(16'h8000, 16'h0000, 16'h0000, 16'h4000);
		send_axis(16'h7fff, 16'h7fff, 16'h7fff, 16'h2000);
		send_axis(16'h8000, 16'h8000, 16'h8000, 16'hc000);
		send_axis(16'h0001, 16'h0000, 16'h0000, 16'h8000);
		send_axis(16'hffff, 16'hffff, 16'hffff, 16'h7fff);
		send_axis(16'h0000, 16'h0000, 16'h0001, 16'h0001);
		// An axis along y under every directed angle, then two mixed axes.
		for (int i = 0; i < 8; i++)
			send_axis(16'h0000, 16'h7fff, 16'h0000, ANGLES[i]);
		send_axis(16'h4000, 16'hc000, 16'h2000, 16'h8000);
		send_axis(16'h5555, 16'haaaa, 16'h0f0f, 16'hffff);

		for (int n = 0; n < 1100; n++) begin
			pause_sender(gap_len());
			// Once, the sender stops until every result is back.
			if (n == 600) begin
				axis_ch.valid <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end
			tiny = ($urandom_range(3) == 0);
			x = rand_comp(tiny);
			y = rand_comp(tiny);
			z = rand_comp(tiny);
			if ($urandom_range(39) == 0) begin
				x = '0; y = '0; z = '0;
			end else if ($urandom_range(9) == 0) begin
				// Axis along a single coordinate.
				case ($urandom_range(2))
					0: begin y = '0; z = '0; end
					1: begin x = '0; z = '0; end
					default: begin x = '0; y = '0; end
				endcase
			end
			send_axis(x, y, z, 16'($urandom()));
		end
		axis_ch.valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// The result side stalls at random, and once holds off for a long
	// stretch while items keep coming, so the pipeline fills and backs up.
	initial begin
		int hold;
		matrix_ch.ready = 1'b0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		matrix_ch.ready <= 1'b0;
		repeat (250) @(posedge clk);
		forever begin
			matrix_ch.ready <= 1'b1;
			repeat ($urandom_range(30, 1)) @(posedge clk);
			hold = gap_len();
			if (hold > 0) begin
				matrix_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Watchdog: cycles in a row with no item moving on either channel.
	always @(posedge clk) begin
		if ((axis_ch.valid && axis_ch.ready) || (matrix_ch.valid && matrix_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == 3000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		do @(posedge clk); while (outstanding != 0);
		// Anything extra the block might still emit shows up here.
		repeat (80) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
